[rtl/glb_pkg.sv]
// ----------------------------------------------------------------------------
// glb_pkg
// Shared types, constants and helpers for the glyph row blitter.
// ----------------------------------------------------------------------------
package glb_pkg;

    localparam int GLYPH_ROWS    = 16;
    localparam int ROW_W         = $clog2(GLYPH_ROWS);
    localparam int FONT_BYTES_DEF = 4096;
    localparam int FONT_INDEX_W  = 12;
    localparam int QUEUE_DEPTH   = 4;

    // configuration register indexes
    localparam logic [2:0] REG_TEXT_COLUMNS = 3'd0;
    localparam logic [2:0] REG_TEXT_ROWS    = 3'd1;
    localparam logic [2:0] REG_LINE_PITCH   = 3'd2;
    localparam logic [2:0] REG_PIXEL_FORMAT = 3'd3;
    localparam logic [2:0] REG_FRAME_BASE   = 3'd4;

    // request kinds carried from front to back
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [FONT_INDEX_W-1:0] font_index;
        logic [7:0]              font_byte;
        logic [6:0]              glyph;
        logic [6:0]              cell_row;
        logic [31:0]             start_addr;
        logic [31:0]             color;
    } glb_cmd_t;

    function automatic logic [31:0] mask_color(input logic [31:0] color,
                                               input logic [1:0]  fmt);
        logic [31:0] m;
        unique case (fmt)
            2'd0:    m = 32'h0000_00ff;
            2'd1:    m = 32'h0000_ffff;
            2'd2:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return color & m;
    endfunction

endpackage

[rtl/glyph_row_blitter.sv]
// ----------------------------------------------------------------------------
// glyph_row_blitter
// Text-mode character generator: renders one character cell per draw request
// into a linear framebuffer as sixteen glyph-row write results.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: tuser = operation (0 load font byte, 1 draw character).
//     A load writes one font byte and gives no result. A draw with column,
//     row or code out of range is dropped. A valid draw gives 16 results.
//   m_ channel: one result per glyph row, top row first; tlast on row 16.
//   cfg port: write enable, register index, data; write only while idle.
// Timing:
//   Requests enter a 4-deep queue; tready drops only when it is full.
//   A draw holds the row sequencer for queue pop, address setup, then 16 rows
//   at one font memory read per cycle unless m_tready stalls; a load ends at its pop.
//   m_tvalid rises after a draw passes queue, setup, read stage and result register.
// Reset clears queue and sequencer, presets config; font store undefined until load.
// When m_tready is low the result register and the read stage hold and the
// sequencer pauses; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module glyph_row_blitter #(
    parameter int FONT_BYTES = glb_pkg::FONT_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] cell_column, [14:8] cell_row, [22:15] char_code, [54:23] ink_color,
    // [66:55] font_index, [74:67] font_byte, [79:75] zero
    input  logic [79:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] write_address, [39:32] pixel_mask, [71:40] pixel_value
    output logic [71:0] m_tdata,
    output logic        m_tlast
);
    import glb_pkg::*;

    glb_cmd_t    push_cmd;
    glb_cmd_t    pop_cmd;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    logic [15:0] line_pitch;

    assign s_tready = !q_full;

    glb_front #(.FONT_BYTES(FONT_BYTES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (s_tvalid),
        .req_op     (s_tuser),
        .req_column (s_tdata[7:0]),
        .req_row    (s_tdata[14:8]),
        .req_code   (s_tdata[22:15]),
        .req_color  (s_tdata[54:23]),
        .req_findex (s_tdata[66:55]),
        .req_fbyte  (s_tdata[74:67]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .line_pitch (line_pitch)
    );

    glb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    glb_back #(.FONT_BYTES(FONT_BYTES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_pitch (line_pitch),
        .q_cmd      (pop_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (m_tdata[31:0]),
        .out_mask   (m_tdata[39:32]),
        .out_value  (m_tdata[71:40]),
        .out_last   (m_tlast)
    );

endmodule

[rtl/glb_front.sv]
// ----------------------------------------------------------------------------
// glb_front
// Holds the configuration, accepts requests and classifies them into font
// loads and draws; out-of-range requests are dropped here.
// ----------------------------------------------------------------------------
module glb_front #(
    parameter int FONT_BYTES = glb_pkg::FONT_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_wdata,
    input  logic             req_valid,
    input  logic             req_op,
    input  logic [7:0]       req_column,
    input  logic [6:0]       req_row,
    input  logic [7:0]       req_code,
    input  logic [31:0]      req_color,
    input  logic [11:0]      req_findex,
    input  logic [7:0]       req_fbyte,
    input  logic             q_full,
    output logic             q_push,
    output glb_pkg::glb_cmd_t q_cmd,
    output logic [15:0]      line_pitch
);
    import glb_pkg::*;

    localparam logic [FONT_INDEX_W:0] FONT_LIMIT = (FONT_INDEX_W+1)'(FONT_BYTES);

    logic [7:0]  text_columns_reg;
    logic [6:0]  text_rows_reg;
    logic [15:0] line_pitch_reg;
    logic [1:0]  pixel_format_reg;
    logic [31:0] frame_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_columns_reg <= 8'd240;
            text_rows_reg    <= 7'd67;
            line_pitch_reg   <= 16'd1920;
            pixel_format_reg <= 2'd0;
            frame_base_reg   <= 32'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEXT_COLUMNS: text_columns_reg <= cfg_wdata[7:0];
                REG_TEXT_ROWS:    text_rows_reg    <= cfg_wdata[6:0];
                REG_LINE_PITCH:   line_pitch_reg   <= cfg_wdata[15:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[1:0];
                REG_FRAME_BASE:   frame_base_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign line_pitch = line_pitch_reg;

    logic        load_ok;
    logic        draw_ok;
    logic [13:0] col_offset;

    // column * 8 * bytes_per_pixel; bytes_per_pixel runs 1..4, so 3 bits
    assign col_offset = {3'b000, req_column, 3'b000}
                      * {11'd0, {1'b0, pixel_format_reg} + 3'd1};

    assign load_ok = ({1'b0, req_findex} < FONT_LIMIT);
    assign draw_ok = (req_column < text_columns_reg) && (req_row < text_rows_reg)
                   && !req_code[7];

    always_comb begin
        q_cmd.kind       = req_op ? KIND_DRAW : KIND_LOAD;
        q_cmd.font_index = req_findex;
        q_cmd.font_byte  = req_fbyte;
        q_cmd.glyph      = req_code[6:0];
        q_cmd.cell_row   = req_row;
        q_cmd.start_addr = frame_base_reg + {18'd0, col_offset};
        q_cmd.color      = mask_color(req_color, pixel_format_reg);
    end

    assign q_push = req_valid && !q_full && (req_op ? draw_ok : load_ok);

endmodule

[rtl/glb_queue.sv]
// ----------------------------------------------------------------------------
// glb_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module glb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  glb_pkg::glb_cmd_t push_cmd,
    input  logic              pop,
    output glb_pkg::glb_cmd_t pop_cmd,
    output logic              full,
    output logic              empty
);
    import glb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    glb_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/glb_back.sv]
// ----------------------------------------------------------------------------
// glb_back
// Font memory and row sequencer: applies loads, walks the glyph rows of a
// draw and feeds the result register.
// ----------------------------------------------------------------------------
module glb_back #(
    parameter int FONT_BYTES = glb_pkg::FONT_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       line_pitch,
    input  glb_pkg::glb_cmd_t q_cmd,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_addr,
    output logic [7:0]        out_mask,
    output logic [31:0]       out_value,
    output logic              out_last
);
    import glb_pkg::*;

    localparam int AW = $clog2(FONT_BYTES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;

    logic [7:0] font_mem [FONT_BYTES];
    logic [7:0] rdata_reg;

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] row_reg;
    logic [6:0]       glyph_reg;
    logic [6:0]       cell_row_reg;
    logic [31:0]      start_reg;
    logic [31:0]      color_reg;
    logic [31:0]      addr_reg;

    logic        rd_valid_reg, rd_valid_next;
    logic [31:0] rd_addr_reg;
    logic [31:0] rd_value_reg;
    logic        rd_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_addr_reg;
    logic [7:0]  out_mask_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        rd_adv;
    logic        issue;
    logic        row_last;
    logic        mem_we;
    logic [26:0] line_offset;

    assign out_free = !out_valid_reg || out_ready;
    assign rd_adv   = rd_valid_reg && out_free;
    assign issue    = (state_reg == ST_ROWS) && (!rd_valid_reg || out_free);
    assign row_last = (row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we   = q_pop && (q_cmd.kind == KIND_LOAD);

    assign line_offset = {11'd0, line_pitch} * {16'd0, cell_row_reg, 4'b0000};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_pop && q_cmd.kind == KIND_DRAW) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_ROWS;
            ST_ROWS:  if (issue && row_last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        rd_valid_next  = issue ? 1'b1 : (rd_adv ? 1'b0 : rd_valid_reg);
        out_valid_next = rd_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            glyph_reg    <= q_cmd.glyph;
            cell_row_reg <= q_cmd.cell_row;
            start_reg    <= q_cmd.start_addr;
            color_reg    <= q_cmd.color;
        end
        if (state_reg == ST_SETUP) begin
            addr_reg <= start_reg + {5'd0, line_offset};
            row_reg  <= '0;
        end else if (issue) begin
            addr_reg <= addr_reg + {16'd0, line_pitch};
            row_reg  <= row_reg + 1'b1;
        end
    end

    // font memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            font_mem[q_cmd.font_index[AW-1:0]] <= q_cmd.font_byte;
        end
        if (issue) begin
            rdata_reg <= font_mem[AW'({glyph_reg, row_reg})];
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_addr_reg  <= addr_reg;
            rd_value_reg <= color_reg;
            rd_last_reg  <= row_last;
        end
        if (rd_adv) begin
            out_addr_reg  <= rd_addr_reg;
            out_mask_reg  <= rdata_reg;
            out_value_reg <= rd_value_reg;
            out_last_reg  <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_mask  = out_mask_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

[tb/sv/glyph_row_blitter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_row_blitter_tb
// Self-checking bench for the glyph row blitter. Font loads and draw requests
// go in on the s_ stream; a local predictor keeps its own font store and
// register copies and queues the sixteen row writes each valid draw should
// give. The m_ stream is checked in order against that queue, under random
// gaps and stalls on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module glyph_row_blitter_tb;
    import glb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 120;

    localparam logic [1:0] FMT_8BPP  = 2'd0;
    localparam logic [1:0] FMT_16BPP = 2'd1;
    localparam logic [1:0] FMT_24BPP = 2'd2;
    localparam logic [1:0] FMT_32BPP = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [7:0]  mask;
        logic [31:0] value;
        logic        last;
    } row_write_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    // predictor state
    logic [7:0]  glyph_mem [0:4095];
    bit          glyph_written [0:4095];
    int          ready_codes[$];
    row_write_t  pending_rows[$];
    logic [7:0]  cfg_cols  = 8'd240;
    logic [6:0]  cfg_rows  = 7'd67;
    logic [15:0] cfg_pitch = 16'd1920;
    logic [1:0]  cfg_fmt   = FMT_8BPP;
    logic [31:0] cfg_base  = 32'd0;

    int mismatch_count = 0;
    int hold_cycles    = 0;
    int stall_left     = 0;
    bit tx_steady      = 1'b0;
    bit rx_steady      = 1'b0;

    glyph_row_blitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void predict_rows(input logic op, input logic [79:0] d);
        logic [7:0]  col;
        logic [6:0]  row;
        logic [7:0]  code;
        logic [31:0] color;
        logic [11:0] fidx;
        int unsigned bpp;
        int unsigned start;
        int unsigned line;
        int          gcode;
        bit          full;
        row_write_t  rw;
        col   = d[7:0];
        row   = d[14:8];
        code  = d[22:15];
        color = d[54:23];
        fidx  = d[66:55];
        if (op == KIND_LOAD) begin
            glyph_mem[fidx] = d[74:67];
            if (!glyph_written[fidx]) begin
                glyph_written[fidx] = 1'b1;
                gcode = int'(fidx) / GLYPH_ROWS;
                full = 1'b1;
                for (int r = 0; r < GLYPH_ROWS; r++)
                    if (!glyph_written[gcode * GLYPH_ROWS + r]) full = 1'b0;
                if (gcode < 128 && full) ready_codes.push_back(gcode);
            end
            return;
        end
        if (col >= cfg_cols || row >= cfg_rows || code >= 8'h80) return;
        case (cfg_fmt)
            FMT_8BPP:  color &= 32'h0000_00ff;
            FMT_16BPP: color &= 32'h0000_ffff;
            FMT_24BPP: color &= 32'h00ff_ffff;
            default:   color &= 32'hffff_ffff;
        endcase
        bpp   = cfg_fmt + 1;
        start = cfg_base + int'(col) * 8 * bpp;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            line     = int'(row) * GLYPH_ROWS + r;
            rw.addr  = start + int'(cfg_pitch) * line;
            rw.mask  = glyph_mem[int'(code) * GLYPH_ROWS + r];
            rw.value = color;
            rw.last  = (r == GLYPH_ROWS - 1);
            pending_rows.push_back(rw);
        end
    endfunction

    function automatic logic [79:0] pack_request(
        input logic [7:0]  col,
        input logic [6:0]  row,
        input logic [7:0]  code,
        input logic [31:0] color,
        input logic [11:0] fidx,
        input logic [7:0]  fbyte
    );
        return {5'd0, fbyte, fidx, color, code, row, col};
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [79:0] data);
        int gap;
        int r;
        gap = 0;
        if (!tx_steady) begin
            r = $urandom_range(0, 99);
            if (r >= 92)      gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_rows(op, data);
    endtask

    task automatic send_load(input logic [11:0] fidx, input logic [7:0] fbyte);
        send_request(KIND_LOAD, pack_request(8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     $urandom(), fidx, fbyte));
    endtask

    task automatic send_draw(input logic [7:0] col, input logic [6:0] row,
                             input logic [7:0] code, input logic [31:0] color);
        send_request(KIND_DRAW, pack_request(col, row, code, color,
                     12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255))));
    endtask

    // drops valid, waits for every expected row, then lets the queue drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEXT_COLUMNS: cfg_cols  = val[7:0];
            REG_TEXT_ROWS:    cfg_rows  = val[6:0];
            REG_LINE_PITCH:   cfg_pitch = val[15:0];
            REG_PIXEL_FORMAT: cfg_fmt   = val[1:0];
            REG_FRAME_BASE:   cfg_base  = val;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [7:0] cols, input logic [6:0] rows,
                                input logic [15:0] pitch, input logic [1:0] fmt,
                                input logic [31:0] base);
        write_reg(REG_TEXT_COLUMNS, {24'd0, cols});
        write_reg(REG_TEXT_ROWS,    {25'd0, rows});
        write_reg(REG_LINE_PITCH,   {16'd0, pitch});
        write_reg(REG_PIXEL_FORMAT, {30'd0, fmt});
        write_reg(REG_FRAME_BASE,   base);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_defaults();
        logic [7:0] fbyte;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            case (r)
                0:       fbyte = 8'h00;
                1:       fbyte = 8'hff;
                2:       fbyte = 8'h80;
                3:       fbyte = 8'h01;
                default: fbyte = 8'($urandom_range(0, 255));
            endcase
            send_load(12'(32'h7f0 + r), fbyte);
        end
        send_draw(8'd0, 7'd0, 8'd127, 32'hffff_ffff);
        send_draw(8'd239, 7'd66, 8'd127, $urandom());
        send_draw(8'd240, 7'd0, 8'd127, $urandom());   // column just out
        send_draw(8'd0, 7'd67, 8'd127, $urandom());    // row just out
        send_draw(8'd0, 7'd0, 8'h80, $urandom());      // code out
        send_draw(8'd0, 7'd0, 8'hff, 32'h0000_0000);
    endtask

    task automatic test_config_extremes();
        wait_idle();
        // far corner with a base near the top: address wraps
        write_config(8'd255, 7'd127, 16'hffff, FMT_32BPP, 32'hffff_ff00);
        send_draw(8'd254, 7'd126, 8'd127, 32'hffff_ffff);
        send_draw(8'd255, 7'd0, 8'd127, $urandom());
        send_draw(8'd0, 7'd127, 8'd127, $urandom());
        send_draw(8'd0, 7'd0, 8'd127, $urandom());
        wait_idle();
        // zero-sized screen drops every draw
        write_config(8'd0, 7'd0, 16'd0, FMT_8BPP, 32'd0);
        send_draw(8'd0, 7'd0, 8'd127, $urandom());
        send_draw(8'd0, 7'd0, 8'd127, $urandom());
        wait_idle();
        write_config(8'd1, 7'd1, 16'd0, FMT_24BPP, 32'h8000_0001);
        send_draw(8'd0, 7'd0, 8'd127, $urandom());
        send_draw(8'd1, 7'd0, 8'd127, $urandom());
    endtask

    // result side holds off while draws keep coming, so the input queue fills
    task automatic test_backpressure();
        wait_idle();
        write_config(8'd80, 7'd30, 16'd2560, FMT_16BPP, $urandom());
        tx_steady   = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 24; i++)
            send_draw(8'($urandom_range(0, 79)), 7'($urandom_range(0, 29)),
                      8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]),
                      $urandom());
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic(input int phases, input int items_per_phase);
        int         count;
        int         r;
        int         n;
        int         code;
        logic [7:0] cols;
        logic [6:0] rows;
        logic [15:0] pitch;
        logic [31:0] base;
        logic [7:0] col;
        logic [6:0] row;
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            r = $urandom_range(0, 9);
            cols  = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 255));
            r = $urandom_range(0, 9);
            rows  = (r == 0) ? 7'd0 : (r == 1) ? 7'd127 : 7'($urandom_range(1, 127));
            r = $urandom_range(0, 9);
            pitch = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
            r = $urandom_range(0, 9);
            base  = (r == 0) ? 32'd0 : (r == 1) ? 32'hffff_ffff : $urandom();
            write_config(cols, rows, pitch, 2'($urandom_range(0, 3)), base);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            count = 0;
            while (count < items_per_phase) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    // glyph upload, now and then cut short
                    code = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 127);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : GLYPH_ROWS;
                    for (int i = 0; i < n; i++)
                        send_load(12'(code * GLYPH_ROWS + i),
                                  ($urandom_range(0, 9) == 0) ? 8'hff
                                                              : 8'($urandom_range(0, 255)));
                    count += n;
                end else if (r < 22) begin
                    send_load(12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
                    count++;
                end else if (r < 85 && cfg_cols != 0 && cfg_rows != 0
                             && ready_codes.size() != 0) begin
                    send_draw(8'($urandom_range(0, cfg_cols - 1)),
                              7'($urandom_range(0, cfg_rows - 1)),
                              8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]),
                              $urandom());
                    count++;
                end else begin
                    // dropped draw; any code below 128 must be a loaded glyph
                    code = (ready_codes.size() != 0)
                         ? ready_codes[$urandom_range(0, ready_codes.size() - 1)]
                         : $urandom_range(128, 255);
                    col = 8'($urandom_range(0, 255));
                    row = 7'($urandom_range(0, 127));
                    case ($urandom_range(0, 2))
                        0:       col = 8'($urandom_range(cfg_cols, 255));
                        1:       row = 7'($urandom_range(cfg_rows, 127));
                        default: code = $urandom_range(128, 255);
                    endcase
                    if (col < cfg_cols && row < cfg_rows && code < 128)
                        code = $urandom_range(128, 255);
                    send_draw(col, row, 8'(code), $urandom());
                    count++;
                end
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : drive_ready
        int r;
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady) begin
                r = $urandom_range(0, 99);
                if (r < 20)      stall_left = $urandom_range(1, 3);
                else if (r < 24) stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin : check_rows
        row_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_rows.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected row write: addr %h mask %h value %h last %b",
                             m_tdata[31:0], m_tdata[39:32], m_tdata[71:40], m_tlast);
                mismatch_count++;
            end else begin
                want = pending_rows.pop_front();
                if (m_tdata[31:0] !== want.addr || m_tdata[39:32] !== want.mask ||
                    m_tdata[71:40] !== want.value || m_tlast !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display("row mismatch: exp addr %h mask %h value %h last %b",
                                 want.addr, want.mask, want.value, want.last);
                        $display("              got addr %h mask %h value %h last %b",
                                 m_tdata[31:0], m_tdata[39:32], m_tdata[71:40], m_tlast);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout, %0d row writes still expected", pending_rows.size());
        $display("FAIL glyph_row_blitter");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 3'd0;
        cfg_wdata = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 80'd0;
        s_tuser   = KIND_LOAD;
        m_tready  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(6, 65);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("PASS glyph_row_blitter");
        end else begin
            $display("FAIL glyph_row_blitter");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/glb_pkg.sv
rtl/glb_front.sv
rtl/glb_queue.sv
rtl/glb_back.sv
rtl/glyph_row_blitter.sv
tb/sv/glyph_row_blitter_tb.sv
